>>> rtl/ptrr_pkg.sv
// Shared types and constants for the paper tape reader register block.
// Holds the command codes, status bit positions and inter-module structs.
// No dependencies.
`timescale 1ns / 1ps

package ptrr_pkg;

  // Bus and tape command codes carried in the input tuser field.
  typedef enum logic [2:0] {
    CMD_READ       = 3'd0,
    CMD_WRITE_WORD = 3'd1,
    CMD_WRITE_BYTE = 3'd2,
    CMD_TAPE_BYTE  = 3'd3,
    CMD_TAPE_FAIL  = 3'd4,
    CMD_DEV_RESET  = 3'd5
  } cmd_e;

  // Configuration register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_BASE     = 2'd0;
  localparam logic [1:0] REG_VECTOR   = 2'd1;
  localparam logic [1:0] REG_PRIORITY = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] BASE_RESET     = 16'd65384;
  localparam logic [7:0]  VECTOR_RESET   = 8'd56;
  localparam logic [2:0]  PRIORITY_RESET = 3'd4;

  // Status word bit positions.
  localparam int unsigned ERROR_BIT = 15;
  localparam int unsigned BUSY_BIT  = 11;
  localparam int unsigned DONE_BIT  = 7;
  localparam int unsigned IE_BIT    = 6;
  localparam int unsigned GO_BIT    = 0;

  // Register offsets inside the four-byte window.
  localparam logic [1:0] OFF_STATUS    = 2'd0;
  localparam logic [1:0] OFF_STATUS_HI = 2'd1;
  localparam logic [1:0] OFF_BUFFER    = 2'd2;
  localparam logic [1:0] OFF_BUFFER_HI = 2'd3;

  // Configuration values seen by the core.
  typedef struct packed {
    logic [15:0] base_address;
    logic [7:0]  interrupt_vector;
    logic [2:0]  interrupt_priority;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  request_level;
    logic [7:0]  request_vector;
    logic        interrupt_request;
    logic [15:0] read_data;
    logic        claimed;
  } result_t;

endpackage

>>> rtl/ptrr_cfg.sv
// APB-style configuration registers: base address, interrupt vector and level.
// Depends on ptrr_pkg.
`timescale 1ns / 1ps

module ptrr_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ptrr_pkg::cfg_t    cfg_o
);
  import ptrr_pkg::*;

  logic [15:0] base_q;
  logic [7:0]  vector_q;
  logic [2:0]  level_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RESET;
      vector_q <= VECTOR_RESET;
      level_q  <= PRIORITY_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_BASE:     base_q   <= pwdata[15:0];
        REG_VECTOR:   vector_q <= pwdata[7:0];
        REG_PRIORITY: level_q  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (paddr[3:2])
      REG_BASE:     prdata = {16'd0, base_q};
      REG_VECTOR:   prdata = {24'd0, vector_q};
      REG_PRIORITY: prdata = {29'd0, level_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{base_address: base_q, interrupt_vector: vector_q,
                   interrupt_priority: level_q};

endmodule

>>> rtl/ptrr_core.sv
// Device state and per-transaction decode of the paper tape reader registers.
// Depends on ptrr_pkg.
`timescale 1ns / 1ps

module ptrr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptrr_pkg::cfg_t     cfg_i,
  input  logic               fire_i,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        address_i,
  input  logic [15:0]        write_data_i,
  input  logic [7:0]         tape_byte_i,
  output ptrr_pkg::result_t  result_o
);
  import ptrr_pkg::*;

  logic       error_q, error_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic       ie_q, ie_d;
  logic [7:0] buffer_q, buffer_d;

  logic [15:0] offset;
  logic        hit;
  logic [1:0]  off_lo;
  logic        tape_err;
  logic        irq;
  logic [15:0] status_word;

  assign offset = address_i - cfg_i.base_address;
  assign hit    = (offset[15:2] == 14'd0);
  assign off_lo = offset[1:0];

  always_comb begin
    status_word           = 16'd0;
    status_word[ERROR_BIT] = error_q;
    status_word[BUSY_BIT]  = busy_q;
    status_word[DONE_BIT]  = done_q;
    status_word[IE_BIT]    = ie_q;
  end

  // Next-state and result decode for one transaction.
  always_comb begin
    error_d  = error_q;
    busy_d   = busy_q;
    done_d   = done_q;
    ie_d     = ie_q;
    buffer_d = buffer_q;
    irq      = 1'b0;
    tape_err = error_q | (cmd_i == CMD_TAPE_FAIL);
    result_o = '0;
    case (cmd_i)
      CMD_READ: begin
        if (hit) begin
          result_o.claimed = 1'b1;
          if (off_lo == OFF_STATUS) begin
            result_o.read_data = status_word;
          end else if (off_lo == OFF_BUFFER) begin
            done_d             = 1'b0;
            result_o.read_data = {8'd0, buffer_q};
          end
        end
      end
      CMD_WRITE_WORD, CMD_WRITE_BYTE: begin
        if (hit) begin
          result_o.claimed = 1'b1;
          if (off_lo == OFF_STATUS) begin
            // Interrupt enable and go sit in the low byte for both widths.
            ie_d = write_data_i[IE_BIT];
            if (write_data_i[GO_BIT]) begin
              busy_d   = 1'b1;
              done_d   = 1'b0;
              buffer_d = 8'd0;
            end
          end else if (off_lo == OFF_BUFFER) begin
            done_d = 1'b0;
          end else if (off_lo == OFF_BUFFER_HI && cmd_i == CMD_WRITE_BYTE) begin
            done_d = 1'b0;
          end
        end
      end
      CMD_TAPE_BYTE, CMD_TAPE_FAIL: begin
        // Tape events end a read cycle only while busy; error is sticky.
        if (busy_q) begin
          busy_d  = 1'b0;
          error_d = tape_err;
          done_d  = ~tape_err;
          if (!tape_err) begin
            buffer_d = tape_byte_i;
          end
          irq = ie_q;
        end
      end
      CMD_DEV_RESET: begin
        error_d  = 1'b0;
        busy_d   = 1'b0;
        done_d   = 1'b0;
        ie_d     = 1'b0;
        buffer_d = 8'd0;
      end
      default: ;
    endcase
    if (irq) begin
      result_o.interrupt_request = 1'b1;
      result_o.request_vector    = cfg_i.interrupt_vector;
      result_o.request_level     = cfg_i.interrupt_priority;
    end
  end

  // State updates on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_q  <= 1'b0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      ie_q     <= 1'b0;
      buffer_q <= 8'd0;
    end else if (fire_i) begin
      error_q  <= error_d;
      busy_q   <= busy_d;
      done_q   <= done_d;
      ie_q     <= ie_d;
      buffer_q <= buffer_d;
    end
  end

endmodule

>>> rtl/ptrr_out_stage.sv
// Result register between the decode logic and the output stream.
// Depends on ptrr_pkg.
`timescale 1ns / 1ps

module ptrr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptrr_pkg::result_t  result_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptrr_pkg::result_t  result_o
);
  import ptrr_pkg::*;

  logic    valid_q;
  result_t data_q;

  // A new result may enter when the register is empty or being drained.
  assign in_ready_o  = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= result_i;
    end
  end

endmodule

>>> rtl/paper_tape_reader_registers.sv
// Paper tape reader register block: status and buffer registers on a bus stream.
// Top level; depends on ptrr_pkg, ptrr_cfg, ptrr_core and ptrr_out_stage.
//
// Usage:
//   The slave stream carries one transaction per item: a bus read, word or
//   byte write, a tape byte, a tape failure or a device reset, chosen by tuser.
//   Each accepted item yields exactly one result on the master stream: the
//   claim flag, read data and any interrupt request with its vector and level.
//   A result becomes valid in the cycle after acceptance. Throughput is one item
//   per cycle while the receiver keeps up, set by the single result register
//   after the decode logic. When the receiver stalls, the result register holds
//   its item and s_axis_tready stays high only while that register is being
//   drained, so no result is lost. The APB port sets the base address, interrupt
//   vector and interrupt level; write it only while the streams are idle.
//   At reset all device flags and the data buffer clear, the result register
//   empties and the configuration returns to base 65384, vector 56, level 4.
//   A device reset command clears the device flags but keeps configuration.
`timescale 1ns / 1ps

module paper_tape_reader_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: address[15:0], write_data[31:16], tape_byte[39:32]
  input  logic [39:0] s_axis_tdata,
  // tuser: cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: claimed[0], read_data[16:1], interrupt_request[17],
  //        request_vector[25:18], request_level[28:26], zero pad[31:29]
  output logic [31:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptrr_pkg::*;

  cfg_t    cfg;
  result_t core_result;
  result_t out_result;
  logic    fire;

  assign fire = s_axis_tvalid & s_axis_tready;

  // Configuration registers.
  ptrr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Device state and decode.
  ptrr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fire_i       (fire),
    .cmd_i        (s_axis_tuser),
    .address_i    (s_axis_tdata[15:0]),
    .write_data_i (s_axis_tdata[31:16]),
    .tape_byte_i  (s_axis_tdata[39:32]),
    .result_o     (core_result)
  );

  // Result register.
  ptrr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .result_i    (core_result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (out_result)
  );

  assign m_axis_tdata = {3'd0, out_result};

endmodule

>>> tb/tb_paper_tape_reader_registers.sv
// Self-checking testbench for the paper tape reader register block.
// Uses ptrr_pkg for command codes, register indexes and the result layout.
// Drives both streams and the APB port, and predicts every result in a scoreboard.
`timescale 1ns / 1ps

module tb_paper_tape_reader_registers;
  import ptrr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS     = 275;

  // Tracks the device registers and flags, and queues one expected result
  // per accepted transaction.
  class reader_scoreboard;
    logic [15:0] base_address = BASE_RESET;
    logic [7:0]  vector       = VECTOR_RESET;
    logic [2:0]  level        = PRIORITY_RESET;
    logic        error_f, busy_f, done_f, ie_f;
    logic [7:0]  tape_buffer;
    result_t     expected_results[$];
    int          mismatches, items, results, claims, interrupts;

    function new();
      clear_device();
    endfunction

    function void clear_device();
      error_f     = 1'b0;
      busy_f      = 1'b0;
      done_f      = 1'b0;
      ie_f        = 1'b0;
      tape_buffer = 8'h00;
    endfunction

    function logic [15:0] status_word();
      logic [15:0] w;
      w            = '0;
      w[ERROR_BIT] = error_f;
      w[BUSY_BIT]  = busy_f;
      w[DONE_BIT]  = done_f;
      w[IE_BIT]    = ie_f;
      return w;
    endfunction

    // A status write loads interrupt enable; the go bit starts a tape read.
    function void write_status(logic [15:0] v);
      ie_f = v[IE_BIT];
      if (v[GO_BIT]) begin
        busy_f      = 1'b1;
        done_f      = 1'b0;
        tape_buffer = 8'h00;
      end
    endfunction

    // Stores a configuration value and returns what a read must give back.
    function logic [31:0] set_register(logic [1:0] idx, logic [31:0] value);
      logic [31:0] kept;
      kept = '0;
      case (idx)
        REG_BASE: begin
          base_address = value[15:0];
          kept[15:0]   = base_address;
        end
        REG_VECTOR: begin
          vector    = value[7:0];
          kept[7:0] = vector;
        end
        REG_PRIORITY: begin
          level     = value[2:0];
          kept[2:0] = level;
        end
        default: ;
      endcase
      return kept;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch in %s (result %0d): expected 0x%0h, got 0x%0h",
                   name, results, want, got);
      end
    endfunction

    // Works out the result of one accepted transaction and updates the device state.
    function void note_item(logic [2:0] cmd, logic [39:0] tdata);
      logic [15:0] addr, wdata, win_off;
      logic [7:0]  tbyte;
      logic        hit, failed;
      result_t     want;
      addr    = tdata[15:0];
      wdata   = tdata[31:16];
      tbyte   = tdata[39:32];
      win_off = addr - base_address;
      hit     = (win_off < 16'd4);
      want    = '0;
      items++;
      case (cmd)
        CMD_READ: begin
          if (hit) begin
            want.claimed = 1'b1;
            if (win_off == OFF_STATUS) begin
              want.read_data = status_word();
            end else if (win_off == OFF_BUFFER) begin
              done_f         = 1'b0;
              want.read_data = {8'h00, tape_buffer};
            end
          end
        end
        CMD_WRITE_WORD: begin
          if (hit) begin
            want.claimed = 1'b1;
            if (win_off == OFF_STATUS) write_status(wdata);
            else if (win_off == OFF_BUFFER) done_f = 1'b0;
          end
        end
        CMD_WRITE_BYTE: begin
          if (hit) begin
            want.claimed = 1'b1;
            if (win_off == OFF_STATUS) write_status({8'h00, wdata[7:0]});
            else if (win_off >= OFF_BUFFER) done_f = 1'b0;
          end
        end
        CMD_TAPE_BYTE, CMD_TAPE_FAIL: begin
          // Tape events only count while a read is in progress; error is sticky.
          if (busy_f) begin
            failed  = error_f || (cmd == CMD_TAPE_FAIL);
            busy_f  = 1'b0;
            error_f = failed;
            done_f  = !failed;
            if (!failed) tape_buffer = tbyte;
            if (ie_f) begin
              want.interrupt_request = 1'b1;
              want.request_vector    = vector;
              want.request_level     = level;
            end
          end
        end
        CMD_DEV_RESET: clear_device();
        default: ;
      endcase
      if (want.claimed) claims++;
      if (want.interrupt_request) interrupts++;
      expected_results.push_back(want);
    endfunction

    function void check_result(logic [31:0] tdata);
      result_t want, got;
      results++;
      got = result_t'(tdata[28:0]);
      if (expected_results.size() == 0) begin
        // A result with no transaction behind it is always an error.
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result %0d: expected none, got 0x%0h", results, tdata);
      end else begin
        want = expected_results.pop_front();
        compare_field("claimed", want.claimed, got.claimed);
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("interrupt_request", want.interrupt_request, got.interrupt_request);
        compare_field("request_vector", want.request_vector, got.request_vector);
        compare_field("request_level", want.request_level, got.request_level);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: address[15:0], write_data[31:16], tape_byte[39:32]
  logic [39:0] s_axis_tdata = '0;
  // tuser: cmd[2:0]
  logic [2:0]  s_axis_tuser = CMD_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: claimed[0], read_data[16:1], interrupt_request[17],
  //        request_vector[25:18], request_level[28:26], zero pad[31:29]
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  reader_scoreboard sb = new();
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int          items_sent = 0;
  int unsigned quiet_cycles = 0;

  paper_tape_reader_registers dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Both streams are sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Ends the run if nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offers one transaction, after random idle cycles, and waits for acceptance.
  task automatic send_item(logic [2:0] cmd, logic [15:0] addr, logic [15:0] wdata,
                           logic [7:0] tbyte);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {tbyte, wdata, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] win_addr(int unsigned off);
    return sb.base_address + 16'(off);
  endfunction

  // Writes a configuration register, then reads it back.
  task automatic config_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    kept = sb.set_register(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.compare_field("register readback", kept, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drains every outstanding result and lets the output stage settle.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Any command, mostly near or inside the register window.
  task automatic noise_item();
    logic [2:0]  cmd;
    logic [15:0] addr;
    if ($urandom_range(99) < 3) cmd = 3'($urandom_range(7, 6));
    else cmd = 3'($urandom_range(5, 0));
    case ($urandom_range(3))
      0, 1:    addr = win_addr($urandom_range(3));
      2:       addr = sb.base_address + 16'($urandom_range(11)) - 16'd4;
      default: addr = 16'($urandom_range(16'hFFFF));
    endcase
    send_item(cmd, addr, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
  endtask

  // A full software read: an optional device reset, start, up to two register
  // accesses, the tape event, then status and buffer reads.
  task automatic read_cycle();
    logic [15:0] wdata;
    logic [2:0]  cmd;
    if ($urandom_range(99) < 40)
      send_item(CMD_DEV_RESET, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                8'($urandom_range(8'hFF)));
    wdata    = 16'($urandom_range(16'hFFFF));
    wdata[0] = 1'b1;
    send_item($urandom_range(1) ? CMD_WRITE_WORD : CMD_WRITE_BYTE, win_addr(0), wdata,
              8'($urandom_range(8'hFF)));
    repeat ($urandom_range(2)) begin
      cmd = 3'($urandom_range(2));
      send_item(cmd, win_addr(cmd == CMD_READ ? $urandom_range(3) : $urandom_range(3, 1)),
                16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
    end
    send_item($urandom_range(99) < 85 ? CMD_TAPE_BYTE : CMD_TAPE_FAIL,
              16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
              8'($urandom_range(8'hFF)));
    send_item(CMD_READ, win_addr(0), 16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
    send_item(CMD_READ, win_addr(2), 16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
  endtask

  task automatic run_traffic(int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) read_cycle();
      else noise_item();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed checks at the reset configuration: window edges, odd offsets,
    // tape events while idle, a good read, a failed read and sticky error.
    send_item(CMD_READ, win_addr(0), 16'h0000, 8'h00);
    send_item(CMD_READ, win_addr(1), 16'h0000, 8'h00);
    send_item(CMD_READ, win_addr(2), 16'h0000, 8'h00);
    send_item(CMD_READ, win_addr(3), 16'h0000, 8'h00);
    send_item(CMD_READ, win_addr(4), 16'h0000, 8'h00);
    send_item(CMD_READ, sb.base_address - 16'd1, 16'h0000, 8'h00);
    send_item(CMD_TAPE_BYTE, 16'h0000, 16'h0000, 8'hFF);
    send_item(CMD_TAPE_FAIL, 16'hFFFF, 16'hFFFF, 8'h00);
    send_item(CMD_WRITE_WORD, win_addr(0), 16'h0041, 8'h00);
    send_item(CMD_READ, win_addr(0), 16'h0000, 8'h00);
    send_item(CMD_TAPE_BYTE, 16'h0000, 16'h0000, 8'hFF);
    send_item(CMD_READ, win_addr(0), 16'h0000, 8'h00);
    send_item(CMD_READ, win_addr(2), 16'h0000, 8'h00);
    send_item(CMD_WRITE_WORD, win_addr(1), 16'hFFFF, 8'h00);
    send_item(CMD_WRITE_BYTE, win_addr(0), 16'hFFC1, 8'h00);
    send_item(CMD_TAPE_FAIL, 16'h0000, 16'h0000, 8'h00);
    send_item(CMD_WRITE_WORD, win_addr(0), 16'h0001, 8'h00);
    send_item(CMD_TAPE_BYTE, 16'h0000, 16'h0000, 8'h5A);
    send_item(CMD_READ, win_addr(0), 16'h0000, 8'h00);
    send_item(CMD_DEV_RESET, 16'h0000, 16'h0000, 8'h00);
    send_item(CMD_WRITE_WORD, win_addr(0), 16'h0041, 8'h00);
    send_item(CMD_TAPE_BYTE, 16'h0000, 16'h0000, 8'h00);
    send_item(CMD_WRITE_BYTE, win_addr(3), 16'h00FF, 8'h00);
    send_item(CMD_READ, win_addr(0), 16'h0000, 8'h00);
    send_item(CMD_WRITE_BYTE, win_addr(1), 16'hFFFF, 8'h00);
    send_item(CMD_WRITE_WORD, win_addr(2), 16'hFFFF, 8'h00);
    send_item(3'd6, win_addr(0), 16'hFFFF, 8'hFF);
    send_item(3'd7, win_addr(2), 16'hFFFF, 8'hFF);

    // Random phases, each with its own configuration and one of four idling patterns.
    for (int ph = 0; ph < 5; ph++) begin
      wait_quiet();
      case (ph)
        0: begin
          config_reg(REG_BASE, 32'h0000_FFFE);
          config_reg(REG_VECTOR, 32'h0000_00A5);
          config_reg(REG_PRIORITY, 32'd3);
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          // Window wrapping past the top of the address space.
          send_item(CMD_READ, 16'h0000, 16'h0000, 8'h00);
          send_item(CMD_READ, 16'h0001, 16'h0000, 8'h00);
          send_item(CMD_WRITE_WORD, 16'hFFFE, 16'h0041, 8'h00);
          send_item(CMD_TAPE_BYTE, 16'h0000, 16'h0000, 8'hC3);
          send_item(CMD_READ, 16'h0002, 16'h0000, 8'h00);
        end
        1: begin
          config_reg(REG_BASE, 32'h0000_0000);
          config_reg(REG_VECTOR, 32'h0000_0000);
          config_reg(REG_PRIORITY, 32'd0);
          src_idle_pct   = 62;
          sink_stall_pct = 0;
        end
        2: begin
          config_reg(REG_BASE, 32'h0000_FFFF);
          config_reg(REG_VECTOR, 32'h0000_00FF);
          config_reg(REG_PRIORITY, 32'd7);
          src_idle_pct   = 0;
          sink_stall_pct = 62;
          hold_off_req   = 1'b1;
        end
        3: begin
          config_reg(REG_BASE, 32'($urandom_range(16'hFFFF)));
          config_reg(REG_VECTOR, 32'($urandom_range(8'hFF)));
          config_reg(REG_PRIORITY, 32'($urandom_range(7)));
          src_idle_pct   = 18;
          sink_stall_pct = 18;
        end
        default: begin
          config_reg(REG_BASE, 32'(BASE_RESET));
          config_reg(REG_VECTOR, 32'(VECTOR_RESET));
          config_reg(REG_PRIORITY, 32'(PRIORITY_RESET));
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      run_traffic(PHASE_ITEMS);
    end

    wait_quiet();
    $display("Ran %0d transactions over five register settings and four idling patterns:",
             sb.items);
    $display("%0d results checked, %0d claimed accesses, %0d interrupt requests, %0d mismatches.",
             sb.results, sb.claims, sb.interrupts, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
